@@ sv/hfd_pkg.sv @@
// hfd_pkg: shared types and constants for the hierarchical FSM dispatcher.
// Used by hfd_ctrl, hfd_datapath and hierarchical_fsm_dispatcher_unit.
`default_nettype none

package hfd_pkg;

	// Table sizes and signal width, fixed by the item field widths
	localparam int MAX_STATES      = 16;
	localparam int MAX_TRANSITIONS = 64;
	localparam int SIGNAL_BITS     = 8;

	localparam int STATE_W = 4;                           // state index field
	localparam int SLOT_W  = 6;                           // slot field
	localparam int SIG_W   = 8;                           // signal field
	localparam int SIDX_W  = $clog2(MAX_STATES);          // parent table index
	localparam int TIDX_W  = $clog2(MAX_TRANSITIONS);     // transition memory index
	localparam int TCNT_W  = 7;                           // transition count register
	localparam int SCNT_W  = 5;                           // state count register
	localparam int LVL_W   = SCNT_W;                      // ancestor level counter

	localparam logic [SIG_W-1:0] SIG_MASK = SIG_W'((32'd1 << SIGNAL_BITS) - 32'd1);

	// APB register map, word index
	localparam int               ADDR_W         = 4;
	localparam logic [1:0]       REG_NUM_STATES = 2'd0;
	localparam logic [1:0]       REG_NUM_TRANS  = 2'd1;
	localparam logic [1:0]       REG_INITIAL    = 2'd2;

	typedef enum logic [1:0] {
		OP_WR_PARENT = 2'd0,
		OP_WR_TRANS  = 2'd1,
		OP_RESTART   = 2'd2,
		OP_DISPATCH  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NOMATCH   = 3'd1,
		STS_BADTARGET = 3'd2,
		STS_WALK      = 3'd3,
		STS_BADINDEX  = 3'd4
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic [SLOT_W-1:0]  slot;
		logic [STATE_W-1:0] parent_state;
		logic               has_parent;
		logic [STATE_W-1:0] from_state;
		logic [SIG_W-1:0]   signal_code;
		logic [STATE_W-1:0] target_state;
		logic               target_valid;
	} item_t;

	typedef struct packed {
		logic               taken;
		status_t            status;
		logic [STATE_W-1:0] current_state;
	} result_t;

	typedef struct packed {
		logic [SCNT_W-1:0]  num_states;
		logic [TCNT_W-1:0]  num_trans;
		logic [STATE_W-1:0] initial_state;
	} cfg_t;

	typedef struct packed {
		logic               has_parent;
		logic [STATE_W-1:0] parent;
	} parent_entry_t;

	typedef struct packed {
		logic [STATE_W-1:0] src;
		logic [SIG_W-1:0]   sig;
		logic [STATE_W-1:0] target;
		logic               target_valid;
	} trans_entry_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_SCAN = 2'd2,
		S_DONE = 2'd3
	} fsm_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic exec;      // decode and run the item's first step
		logic scan;      // one step of the transition scan
		logic emit;      // move the finished result to the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic exec_final;   // item finished in its first step
		logic scan_final;   // scan found its answer this cycle
	} dp_status_t;

endpackage

`default_nettype wire

@@ sv/hierarchical_fsm_dispatcher_unit.sv @@
// Hierarchical FSM dispatcher, top level. An accepted item passes through exec and then
// done; a dispatch that does not fail at once also scans the transitions in use at each
// level walked, stopping at the first match.
// One item at a time, paced by the scan (one entry per cycle, single read port). The next
// item is accepted the cycle after its result loads; a finished result waits for the last.
// Async reset: idle, no result pending, current state 0, registers 1/0/0; tables undefined.
`default_nettype none

module hierarchical_fsm_dispatcher_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	// item channel
	input  wire                          item_valid,
	output logic                         item_ready,
	input  hfd_pkg::item_t               item,
	// result channel
	output logic                         result_valid,
	input  wire                          result_ready,
	output hfd_pkg::result_t             result,
	// APB register port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [hfd_pkg::ADDR_W-1:0]   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	hfd_pkg::cfg_t       cfg_q;
	hfd_pkg::dp_cmd_t    cmd;
	hfd_pkg::dp_status_t sts;
	hfd_pkg::fsm_state_t state;
	logic                cfg_wr;
	logic [1:0]          reg_idx;

	// ---------------------------------------------------------------
	// Register block. Zero wait state; a transaction completes in the
	// access phase. Word index is paddr[3:2]; the byte offset is ignored.
	// Writes are only to be issued while the unit is idle; the block does not enforce it.
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_states    <= hfd_pkg::SCNT_W'(1);
			cfg_q.num_trans     <= '0;
			cfg_q.initial_state <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hfd_pkg::REG_NUM_STATES:
					cfg_q.num_states <= pwdata[hfd_pkg::SCNT_W-1:0];
				hfd_pkg::REG_NUM_TRANS:
					cfg_q.num_trans <= pwdata[hfd_pkg::TCNT_W-1:0];
				hfd_pkg::REG_INITIAL:
					cfg_q.initial_state <= pwdata[hfd_pkg::STATE_W-1:0];
				default: ;  // unmapped: write ignored
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hfd_pkg::REG_NUM_STATES: prdata = 32'(cfg_q.num_states);
			hfd_pkg::REG_NUM_TRANS:  prdata = 32'(cfg_q.num_trans);
			hfd_pkg::REG_INITIAL:    prdata = 32'(cfg_q.initial_state);
			default:                 prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Controller: idle -> exec -> (scan)* -> done -> idle.
	// It owns item_ready and result_valid; the datapath owns payloads.
	// ---------------------------------------------------------------
	hfd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd),
		.state        (state)
	);

	// ---------------------------------------------------------------
	// Datapath: parent table (flops), transition memory (registered
	// read), walk state, level counter, and the result registers.
	// During a dispatch the scan issues one memory read per cycle and
	// compares the entry read the cycle before; at the end of a level
	// it ends the walk or climbs to the parent and restarts at entry 0.
	// ---------------------------------------------------------------
	hfd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// exec runs exactly in the cycle after an accepted transaction
	a_exec_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $past(item_valid && item_ready))
		else $error("exec without a preceding accepted transaction");

	// a finished result never overwrites one still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!result_valid || result_ready))
		else $error("result register overwritten while pending");

	// one item in flight: no accept in the cycle after an accept
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second item accepted while busy");

	// the scan only runs in the scan state
	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (state == hfd_pkg::S_SCAN))
		else $error("scan step outside scan state");

	// a taken result always reports success
	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.taken) |-> (result.status == hfd_pkg::STS_OK))
		else $error("taken result with failure status");

endmodule

`default_nettype wire

@@ sv/hfd_ctrl.sv @@
// hfd_ctrl: sequencing FSM for the dispatcher; owns both handshakes.
// Depends on hfd_pkg; drives hfd_datapath through dp_cmd_t.
`default_nettype none

module hfd_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  wire                 result_ready,
	input  hfd_pkg::dp_status_t sts,
	output hfd_pkg::dp_cmd_t    cmd,
	output hfd_pkg::fsm_state_t state
);

	hfd_pkg::fsm_state_t state_q, state_nxt;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			hfd_pkg::S_IDLE: begin
				if (item_valid) state_nxt = hfd_pkg::S_EXEC;
			end
			hfd_pkg::S_EXEC: begin
				state_nxt = sts.exec_final ? hfd_pkg::S_DONE : hfd_pkg::S_SCAN;
			end
			hfd_pkg::S_SCAN: begin
				if (sts.scan_final) state_nxt = hfd_pkg::S_DONE;
			end
			hfd_pkg::S_DONE: begin
				if (out_free) state_nxt = hfd_pkg::S_IDLE;
			end
			default: state_nxt = hfd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		item_ready  = 1'b0;
		unique case (state_q)
			hfd_pkg::S_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			hfd_pkg::S_EXEC: cmd.exec = 1'b1;
			hfd_pkg::S_SCAN: cmd.scan = 1'b1;
			hfd_pkg::S_DONE: cmd.emit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hfd_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign state        = state_q;

endmodule

`default_nettype wire

@@ sv/hfd_datapath.sv @@
// hfd_datapath: parent table, transition memory, scan counters, result registers.
// Depends on hfd_pkg; stepped by hfd_ctrl through dp_cmd_t.
`default_nettype none

module hfd_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  hfd_pkg::cfg_t       cfg,
	input  hfd_pkg::item_t      item,
	input  hfd_pkg::dp_cmd_t    cmd,
	output hfd_pkg::dp_status_t sts,
	output hfd_pkg::result_t    result
);

	localparam logic [hfd_pkg::SCNT_W-1:0] SC_MAX = hfd_pkg::SCNT_W'(hfd_pkg::MAX_STATES);
	localparam logic [hfd_pkg::TCNT_W-1:0] TC_MAX = hfd_pkg::TCNT_W'(hfd_pkg::MAX_TRANSITIONS);

	hfd_pkg::parent_entry_t par_q [hfd_pkg::MAX_STATES];
	hfd_pkg::trans_entry_t  tmem  [hfd_pkg::MAX_TRANSITIONS];

	hfd_pkg::item_t               item_q;
	hfd_pkg::result_t             res_q, out_q, res_nxt;
	hfd_pkg::trans_entry_t        rd_s1, wr_entry;
	logic                         rdv_s1;
	logic [hfd_pkg::STATE_W-1:0]  cur_q, s_q, cur_nxt;
	logic [hfd_pkg::LVL_W-1:0]    lvl_q, lvl_next;
	logic [hfd_pkg::TCNT_W-1:0]   addr_q;

	logic [hfd_pkg::SCNT_W-1:0]   sc;
	logic [hfd_pkg::TCNT_W-1:0]   tc;
	logic [hfd_pkg::SIG_W-1:0]    sig;
	hfd_pkg::parent_entry_t       par_rd;
	logic                         par_we, tr_we, cur_we;
	logic                         issue, hit, lvl_end, climb, final_exec, final_scan;

	assign sc       = (cfg.num_states > SC_MAX) ? SC_MAX : cfg.num_states;
	assign tc       = (cfg.num_trans > TC_MAX) ? TC_MAX : cfg.num_trans;
	assign sig      = item_q.signal_code & hfd_pkg::SIG_MASK;
	assign par_rd   = par_q[s_q[hfd_pkg::SIDX_W-1:0]];
	assign lvl_next = lvl_q + 1'b1;
	assign issue    = addr_q < tc;
	assign hit      = rdv_s1 && (rd_s1.src == s_q) && (rd_s1.sig == sig);
	assign lvl_end  = !rdv_s1 && !issue;
	assign climb    = lvl_end && par_rd.has_parent
	                  && ({1'b0, par_rd.parent} < sc) && (lvl_next < sc);

	assign wr_entry = '{src: item_q.from_state, sig: sig,
	                    target: item_q.target_state, target_valid: item_q.target_valid};

	always_comb begin
		res_nxt    = '{taken: 1'b0, status: hfd_pkg::STS_OK, current_state: cur_q};
		cur_nxt    = cur_q;
		cur_we     = 1'b0;
		par_we     = 1'b0;
		tr_we      = 1'b0;
		final_exec = 1'b1;
		final_scan = 1'b0;
		if (cmd.exec) begin
			unique case (item_q.operation)
				hfd_pkg::OP_WR_PARENT: begin
					if (item_q.slot < hfd_pkg::SLOT_W'(hfd_pkg::MAX_STATES)) begin
						par_we        = 1'b1;
						res_nxt.taken = 1'b1;
					end else begin
						res_nxt.status = hfd_pkg::STS_BADINDEX;
					end
				end
				hfd_pkg::OP_WR_TRANS: begin
					if (hfd_pkg::TCNT_W'(item_q.slot) < TC_MAX) begin
						tr_we         = 1'b1;
						res_nxt.taken = 1'b1;
					end else begin
						res_nxt.status = hfd_pkg::STS_BADINDEX;
					end
				end
				hfd_pkg::OP_RESTART: begin
					if ({1'b0, cfg.initial_state} < sc) begin
						cur_nxt       = cfg.initial_state;
						cur_we        = 1'b1;
						res_nxt.taken = 1'b1;
					end else begin
						res_nxt.status = hfd_pkg::STS_BADINDEX;
					end
				end
				hfd_pkg::OP_DISPATCH: begin
					if ({1'b0, cur_q} < sc)
						final_exec = 1'b0;
					else
						res_nxt.status = hfd_pkg::STS_NOMATCH;
				end
				default: res_nxt.status = hfd_pkg::STS_BADINDEX;
			endcase
		end else if (cmd.scan) begin
			priority if (hit) begin
				final_scan = 1'b1;
				if (!rd_s1.target_valid || ({1'b0, rd_s1.target} >= sc)) begin
					res_nxt.status = hfd_pkg::STS_BADTARGET;
				end else begin
					cur_nxt       = rd_s1.target;
					cur_we        = 1'b1;
					res_nxt.taken = 1'b1;
				end
			end else if (lvl_end && !climb) begin
				final_scan = 1'b1;
				// no parent or parent out of range ends the walk as no-match
				if (!par_rd.has_parent || ({1'b0, par_rd.parent} >= sc))
					res_nxt.status = hfd_pkg::STS_NOMATCH;
				else
					res_nxt.status = hfd_pkg::STS_WALK;
			end else begin
				final_scan = 1'b0;
			end
		end
		res_nxt.current_state = cur_nxt;
	end

	assign sts.exec_final = final_exec;
	assign sts.scan_final = final_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			if (cur_we) cur_q <= cur_nxt;
			if (cmd.scan && issue && !climb)
				rdv_s1 <= 1'b1;
			else
				rdv_s1 <= 1'b0;
		end
	end

	// Scan counters: the address runs ahead of the compare, which sees the entry addressed in the previous cycle
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.exec) begin
			s_q    <= cur_q;
			addr_q <= '0;
			lvl_q  <= '0;
		end else if (cmd.scan) begin
			if (climb) begin
				s_q    <= par_rd.parent;
				addr_q <= '0;
				lvl_q  <= lvl_next;
			end else if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
		end
		if ((cmd.exec && final_exec) || (cmd.scan && final_scan)) res_q <= res_nxt;
		if (cmd.emit) out_q <= res_q;
		if (par_we) par_q[item_q.slot[hfd_pkg::SIDX_W-1:0]] <=
			'{has_parent: item_q.has_parent, parent: item_q.parent_state};
	end

	// Transition memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (tr_we) tmem[item_q.slot[hfd_pkg::TIDX_W-1:0]] <= wr_entry;
		rd_s1 <= tmem[addr_q[hfd_pkg::TIDX_W-1:0]];
	end

	assign result = out_q;

endmodule

`default_nettype wire

@@ bench/tb_hierarchical_fsm_dispatcher_unit.sv @@
`timescale 1ns / 100ps
// Testbench for hierarchical_fsm_dispatcher_unit: directed and random table loads,
// restarts and dispatches, checked against an in-bench state machine predictor.
// Depends on hfd_pkg (sv/hfd_pkg.sv) and the unit RTL.

module tb_hierarchical_fsm_dispatcher_unit;

	// Limit on the length of the whole run; this only stops a hang
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_PAUSE = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_ready;
	hfd_pkg::item_t item_bus = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	hfd_pkg::result_t result_bus;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [hfd_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	hierarchical_fsm_dispatcher_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item_bus),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: settings, current state and both tables
	// ------------------------------------------------------------------
	hfd_pkg::cfg_t cfg = '{num_states: 5'd1, num_trans: 7'd0, initial_state: 4'd0};
	logic [hfd_pkg::STATE_W-1:0] cur_state = '0;
	hfd_pkg::parent_entry_t parents[hfd_pkg::MAX_STATES];
	hfd_pkg::trans_entry_t transitions[hfd_pkg::MAX_TRANSITIONS];

	// Which table entries the stimulus has written so far. A dispatch is only
	// issued once every entry it could look at has been written.
	bit par_written[hfd_pkg::MAX_STATES];
	bit tr_written[hfd_pkg::MAX_TRANSITIONS];

	hfd_pkg::item_t pending_items[$];
	hfd_pkg::result_t expected_results[$];

	int err_count = 0;
	int results_seen = 0;
	int cycle_count = 0;

	// Registers above the table sizes saturate
	function automatic int eff_states();
		return (cfg.num_states > hfd_pkg::MAX_STATES) ? hfd_pkg::MAX_STATES
			: int'(cfg.num_states);
	endfunction

	function automatic int eff_trans();
		return (cfg.num_trans > hfd_pkg::MAX_TRANSITIONS) ? hfd_pkg::MAX_TRANSITIONS
			: int'(cfg.num_trans);
	endfunction

	// Applies one transaction to the predictor and returns the result it must produce
	function automatic hfd_pkg::result_t next_hsm_result(input hfd_pkg::item_t it);
		hfd_pkg::result_t res;
		int sc;
		int tc;
		int lvl;
		int t;
		logic [hfd_pkg::STATE_W-1:0] s;
		logic [hfd_pkg::SIG_W-1:0] sig;
		bit done;
		res.taken = 1'b0;
		res.status = hfd_pkg::STS_OK;
		sc = eff_states();
		tc = eff_trans();
		sig = it.signal_code & hfd_pkg::SIG_MASK;
		case (it.operation)
			hfd_pkg::OP_WR_PARENT: begin
				if (it.slot < hfd_pkg::MAX_STATES) begin
					parents[it.slot[hfd_pkg::SIDX_W-1:0]] = '{it.has_parent, it.parent_state};
					res.taken = 1'b1;
				end else begin
					res.status = hfd_pkg::STS_BADINDEX;
				end
			end
			hfd_pkg::OP_WR_TRANS: begin
				transitions[it.slot] = '{it.from_state, sig, it.target_state, it.target_valid};
				res.taken = 1'b1;
			end
			hfd_pkg::OP_RESTART: begin
				if (cfg.initial_state < sc) begin
					cur_state = cfg.initial_state;
					res.taken = 1'b1;
				end else begin
					res.status = hfd_pkg::STS_BADINDEX;
				end
			end
			hfd_pkg::OP_DISPATCH: begin
				s = cur_state;
				lvl = 0;
				done = 1'b0;
				if (s >= sc) begin
					res.status = hfd_pkg::STS_NOMATCH;
					done = 1'b1;
				end
				while (!done) begin
					// first matching entry in table order decides, good target or not
					for (t = 0; t < tc && !done; t++) begin
						if (transitions[t].src == s && transitions[t].sig == sig) begin
							done = 1'b1;
							if (!transitions[t].target_valid || transitions[t].target >= sc) begin
								res.status = hfd_pkg::STS_BADTARGET;
							end else begin
								cur_state = transitions[t].target;
								res.taken = 1'b1;
							end
						end
					end
					if (!done) begin
						lvl++;
						if (!parents[s].has_parent || parents[s].parent >= sc) begin
							res.status = hfd_pkg::STS_NOMATCH;
							done = 1'b1;
						end else if (lvl >= sc) begin
							// only a loop in the parent links gets this far
							res.status = hfd_pkg::STS_WALK;
							done = 1'b1;
						end else begin
							s = parents[s].parent;
						end
					end
				end
			end
		endcase
		res.current_state = cur_state;
		return res;
	endfunction

	task automatic report_error(input string what);
		if (err_count < 100)
			$display("ERROR @%0t: %s", $realtime, what);
		err_count++;
	endtask

	// Mostly short gaps, a few long ones, none at all while calm
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 48);
	endfunction

	// ------------------------------------------------------------------
	// Item driver: sends pending_items, predicts on every accepted transaction
	// ------------------------------------------------------------------
	int src_gap = 0;
	bit src_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(next_hsm_result(item_bus));
			// payload only moves once the current transaction is gone
			if (!item_valid || item_ready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item_bus <= pending_items.pop_front();
					item_valid <= 1'b1;
					src_gap <= pick_gap(src_calm);
					if ($urandom_range(0, 99) < 3)
						src_calm <= !src_calm;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random back-pressure, in-order field compare
	// ------------------------------------------------------------------
	int snk_stall = 0;
	int snk_pick;
	bit snk_calm = 1'b0;

	task automatic check_result(input hfd_pkg::result_t got);
		hfd_pkg::result_t want;
		if (expected_results.size() == 0) begin
			report_error($sformatf("result %0d with no transaction outstanding", results_seen));
			return;
		end
		want = expected_results.pop_front();
		if (got.taken !== want.taken)
			report_error($sformatf("result %0d taken %b, want %b",
				results_seen, got.taken, want.taken));
		if (got.status !== want.status)
			report_error($sformatf("result %0d status %0d, want %0d",
				results_seen, got.status, want.status));
		if (got.current_state !== want.current_state)
			report_error($sformatf("result %0d current_state %0d, want %0d",
				results_seen, got.current_state, want.current_state));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			snk_stall <= 0;
		end else if (result_valid && result_ready) begin
			check_result(result_bus);
			results_seen++;
			snk_pick = pick_gap(snk_calm);
			snk_stall <= snk_pick;
			result_ready <= (snk_pick == 0);
			if ($urandom_range(0, 99) < 3)
				snk_calm <= !snk_calm;
		end else if (snk_stall > 0) begin
			snk_stall <= snk_stall - 1;
			result_ready <= (snk_stall == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic hfd_pkg::item_t mk(input hfd_pkg::op_t op, input int slot,
			input int parent, input bit has, input int from, input int sig,
			input int target, input bit tvalid);
		hfd_pkg::item_t it;
		it.operation = op;
		it.slot = hfd_pkg::SLOT_W'(slot);
		it.parent_state = hfd_pkg::STATE_W'(parent);
		it.has_parent = has;
		it.from_state = hfd_pkg::STATE_W'(from);
		it.signal_code = hfd_pkg::SIG_W'(sig);
		it.target_state = hfd_pkg::STATE_W'(target);
		it.target_valid = tvalid;
		return it;
	endfunction

	function automatic void push_item(input hfd_pkg::item_t it);
		if (it.operation == hfd_pkg::OP_WR_PARENT && it.slot < hfd_pkg::MAX_STATES)
			par_written[it.slot] = 1'b1;
		if (it.operation == hfd_pkg::OP_WR_TRANS)
			tr_written[it.slot] = 1'b1;
		pending_items.push_back(it);
	endfunction

	// Random bits in all fields but the operation; the builders below shape them toward a tree of states
	function automatic hfd_pkg::item_t random_raw(input hfd_pkg::op_t op);
		logic [31:0] raw;
		hfd_pkg::item_t it;
		raw = $urandom;
		it = raw[$bits(hfd_pkg::item_t)-1:0];
		it.operation = op;
		return it;
	endfunction

	function automatic hfd_pkg::item_t parent_entry_item(input int slot);
		hfd_pkg::item_t it;
		int r;
		it = random_raw(hfd_pkg::OP_WR_PARENT);
		it.slot = hfd_pkg::SLOT_W'(slot);
		r = $urandom_range(0, 99);
		// state 0 is the usual root; the odd random link may close a loop
		// or point past the states in use
		it.has_parent = (slot != 0 && r >= 8) || r >= 96;
		if (slot > 0 && r < 88)
			it.parent_state = hfd_pkg::STATE_W'($urandom_range(0, slot - 1));
		return it;
	endfunction

	function automatic hfd_pkg::item_t trans_entry_item(input int slot);
		hfd_pkg::item_t it;
		int sc;
		it = random_raw(hfd_pkg::OP_WR_TRANS);
		it.slot = hfd_pkg::SLOT_W'(slot);
		sc = eff_states();
		if (sc > 0 && $urandom_range(0, 99) < 90)
			it.from_state = hfd_pkg::STATE_W'($urandom_range(0, sc - 1));
		if ($urandom_range(0, 99) < 85)
			it.signal_code = hfd_pkg::SIG_W'($urandom_range(0, 7));
		if (sc > 0 && $urandom_range(0, 99) < 88)
			it.target_state = hfd_pkg::STATE_W'($urandom_range(0, sc - 1));
		it.target_valid = ($urandom_range(0, 99) < 90);
		return it;
	endfunction

	// Wait until every transaction has been sent and answered, then a short pause
	// so a late extra result would still be seen
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	// APB write followed back to back by a read of the same register
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		readback = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== value)
			report_error($sformatf("register %0d read 0x%0h, want 0x%0h", idx, readback, value));
		case (idx)
			hfd_pkg::REG_NUM_STATES: cfg.num_states = value[hfd_pkg::SCNT_W-1:0];
			hfd_pkg::REG_NUM_TRANS: cfg.num_trans = value[hfd_pkg::TCNT_W-1:0];
			hfd_pkg::REG_INITIAL: cfg.initial_state = value[hfd_pkg::STATE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int sc, input int tc, input int init_state);
		write_reg(hfd_pkg::REG_NUM_STATES, 32'(sc));
		write_reg(hfd_pkg::REG_NUM_TRANS, 32'(tc));
		write_reg(hfd_pkg::REG_INITIAL, 32'(init_state));
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int phase;
		int random_items;
		int n;
		int i;
		int r;
		int sc_reg;
		int tc_reg;
		hfd_pkg::item_t it;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: one state, no transitions in use.
		// Out-of-range parent slots, field extremes, restart, empty-table dispatch.
		push_item(mk(hfd_pkg::OP_WR_PARENT, 0, 15, 1'b0, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_PARENT, 63, 15, 1'b1, 15, 255, 15, 1'b1));
		push_item(mk(hfd_pkg::OP_WR_PARENT, 16, 0, 1'b1, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 63, 0, 1'b0, 15, 255, 15, 1'b1));
		push_item(mk(hfd_pkg::OP_RESTART, 0, 0, 1'b0, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 255, 0, 1'b0));
		wait_drained();

		// No states at all: restart is a bad index, dispatch finds nothing
		configure(0, 0, 15);
		push_item(mk(hfd_pkg::OP_RESTART, 0, 0, 1'b0, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 0, 0, 1'b0));
		wait_drained();

		// Chain 3 -> 2 -> 1 -> 0 with a small table: local match, inherited
		// bad target, invalid target, no match, then a loop through state 0
		configure(4, 6, 3);
		push_item(mk(hfd_pkg::OP_WR_PARENT, 1, 0, 1'b1, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_PARENT, 2, 1, 1'b1, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_PARENT, 3, 2, 1'b1, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 0, 0, 1'b0, 0, 8'h10, 1, 1'b1));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 1, 0, 1'b0, 2, 8'h20, 15, 1'b1));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 2, 0, 1'b0, 1, 8'h30, 2, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 3, 0, 1'b0, 3, 8'h10, 0, 1'b1));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 4, 0, 1'b0, 0, 8'hFF, 3, 1'b1));
		push_item(mk(hfd_pkg::OP_WR_TRANS, 5, 0, 1'b0, 2, 8'h20, 0, 1'b1));
		push_item(mk(hfd_pkg::OP_RESTART, 0, 0, 1'b0, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h10, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'hFF, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h20, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h30, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h55, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_WR_PARENT, 0, 3, 1'b1, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h55, 0, 1'b0));
		wait_drained();

		// Shrink to two states: current state 3 is now unknown, and the
		// link from state 0 to 3 points past the states in use
		configure(2, 6, 1);
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h55, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_RESTART, 0, 0, 1'b0, 0, 0, 0, 1'b0));
		push_item(mk(hfd_pkg::OP_DISPATCH, 0, 0, 1'b0, 0, 8'h55, 0, 1'b0));

		// Random phases. The first few pin the register extremes.
		phase = 0;
		random_items = 0;
		while (random_items < 545) begin
			wait_drained();
			case (phase)
				0: configure(16, 64, 15);
				1: configure(31, 127, 0);
				2: configure(1, 1, 0);
				3: configure(16, 0, 7);
				default: begin
					r = $urandom_range(0, 99);
					sc_reg = (r < 85) ? $urandom_range(1, 16)
						: (r < 93) ? 0 : $urandom_range(17, 31);
					r = $urandom_range(0, 99);
					tc_reg = (r < 70) ? $urandom_range(0, 16)
						: (r < 90) ? $urandom_range(17, 64) : $urandom_range(65, 127);
					configure(sc_reg, tc_reg, $urandom_range(0, 15));
				end
			endcase

			// Every entry a dispatch can reach gets written before the first one
			for (i = 0; i < eff_states(); i++)
				if (!par_written[i]) begin
					push_item(parent_entry_item(i));
					random_items++;
				end
			for (i = 0; i < eff_trans(); i++)
				if (!tr_written[i]) begin
					push_item(trans_entry_item(i));
					random_items++;
				end

			n = $urandom_range(15, 45);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					// signals mostly from the small set the table uses
					it = random_raw(hfd_pkg::OP_DISPATCH);
					if ($urandom_range(0, 99) < 85)
						it.signal_code = hfd_pkg::SIG_W'($urandom_range(0, 7));
				end else if (r < 74) begin
					if (eff_trans() > 0 && $urandom_range(0, 99) < 75)
						it = trans_entry_item($urandom_range(0, eff_trans() - 1));
					else
						it = trans_entry_item($urandom_range(0, hfd_pkg::MAX_TRANSITIONS - 1));
				end else if (r < 86) begin
					if ($urandom_range(0, 99) < 85)
						it = parent_entry_item($urandom_range(0, hfd_pkg::MAX_STATES - 1));
					else
						it = parent_entry_item($urandom_range(hfd_pkg::MAX_STATES, 63));
				end else begin
					it = random_raw(hfd_pkg::OP_RESTART);
				end
				push_item(it);
				random_items++;
			end
			phase++;
		end

		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/hfd_pkg.sv
sv/hfd_ctrl.sv
sv/hfd_datapath.sv
sv/hierarchical_fsm_dispatcher_unit.sv
bench/tb_hierarchical_fsm_dispatcher_unit.sv
